// ===== rtl/mip_pkg.sv =====
// ----------------------------------------------------------------------------
// mip_pkg
// Shared field widths, action codes and the stored element type for the
// multiway in-place partition unit.
// ----------------------------------------------------------------------------
package mip_pkg;

  localparam int unsigned ActW  = 3;
  localparam int unsigned AddrW = 12;
  localparam int unsigned ValW  = 32;
  localparam int unsigned LenW  = 13;
  localparam int unsigned BndOW = 14;

  // Request action codes.
  typedef enum logic [ActW-1:0] {
    ACT_LOAD_EL  = 3'd0,
    ACT_LOAD_PIV = 3'd1,
    ACT_START    = 3'd2,
    ACT_READ_EL  = 3'd3,
    ACT_READ_BND = 3'd4
  } action_e;

  // One stored element: its value and the address it was loaded at.
  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [AddrW-1:0]       origin;
  } elem_t;

endpackage

// ===== rtl/multiway_inplace_partition_unit.sv =====
// ----------------------------------------------------------------------------
// multiway_inplace_partition_unit
// Loads elements and pivots, partitions the elements in place into ranges
// and reads back elements, origins and final boundaries.
// ----------------------------------------------------------------------------
// A load element, load pivot or read boundary request is answered from S_IDLE,
// and a read element request passes through S_RDEL for the registered read of
// the element memory. A start request runs a data-dependent walk over the
// element memory, one read and one write at most per cycle: every head check
// is a compare and read (S_L_CHK, S_R_CHK), then the value test (S_L_EV,
// S_R_EV), placing a scanned element ends with its final write, every ripple
// move through a boundary is one read (S_RP_STEP) and one write (S_RP_MOVE),
// and a swap adds the read of the left element, a second ripple and S_PUT_LO.
// No request is taken while a run is in progress.
module multiway_inplace_partition_unit
  import mip_pkg::*;
#(
  parameter int unsigned DEPTH      = 4096,
  parameter int unsigned NUM_PIVOTS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ActW-1:0]          action_i,
  input  logic [AddrW-1:0]         address_i,
  input  logic signed [ValW-1:0]   data_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValW-1:0]   read_value_o,
  output logic [AddrW-1:0]         origin_index_o,
  output logic signed [BndOW-1:0]  boundary_value_o,
  output logic                     run_done_o,
  input  logic                     cfg_we_i,
  input  logic [LenW-1:0]          cfg_wdata_i
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BW  = $clog2(DEPTH + 1) + 1;
  localparam int unsigned PIW = (NUM_PIVOTS > 1) ? $clog2(NUM_PIVOTS) : 1;
  localparam int unsigned IW  = PIW + 1;
  localparam int unsigned MID = NUM_PIVOTS / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_RDEL, S_L_CHK, S_L_EV, S_R_CHK, S_R_EV, S_SW_EV,
    S_RP_STEP, S_RP_MOVE, S_PUT_LO
  } state_e;

  typedef enum logic [1:0] {RET_L, RET_R, RET_SWH, RET_SWL} ret_e;

  state_e state_q;
  ret_e   ret_q;
  logic   dir_hi_q;

  logic [LenW-1:0]        len_q;
  logic signed [ValW-1:0] piv_q [NUM_PIVOTS];
  logic signed [BW-1:0]   bnd_q [NUM_PIVOTS];

  logic signed [ValW-1:0] cur_v_q, rv_q, mp_q;
  logic [AddrW-1:0]       cur_o_q, ro_q;
  logic signed [BW-1:0]   hole_q, hole_hi_q, src_q;
  logic signed [IW-1:0]   idx_q;

  logic                   ov_q, done_q;
  logic signed [ValW-1:0] rval_q;
  logic [AddrW-1:0]       rorg_q;
  logic signed [BndOW-1:0] rbnd_q;

  // Memory port.
  logic          m_we, m_re;
  logic [AW-1:0] m_waddr, m_raddr;
  elem_t         m_wdata, m_rdata;

  mip_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  // Map a boundary pointer to a memory slot; out-of-range pointers use slot 0.
  function automatic logic [AW-1:0] slot(input logic signed [BW-1:0] p);
    logic [AW-1:0] r;
    r = '0;
    if (!p[BW-1] && (p < BW'(DEPTH))) begin
      r = AW'(p);
    end
    return r;
  endfunction

  logic signed [BW-1:0] lh, rh;
  assign lh = bnd_q[MID-1];
  assign rh = bnd_q[MID];

  logic in_acc, out_acc;
  assign in_ready_o = (state_q == S_IDLE) && (!ov_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = ov_q && out_ready_i;

  logic el_ok, piv_ok;
  assign el_ok  = ({20'd0, address_i} < 32'(DEPTH));
  assign piv_ok = ({20'd0, address_i} < 32'(NUM_PIVOTS));

  // Effective length minus one for the upper boundary start.
  logic signed [BW-1:0] len_m1;
  always_comb begin
    if (len_q == '0) begin
      len_m1 = '0;
    end else if (32'(len_q) > 32'(DEPTH)) begin
      len_m1 = BW'(DEPTH - 1);
    end else begin
      len_m1 = BW'(len_q) - BW'(1);
    end
  end

  // Ripple step decision: the shared pivot compare.
  logic signed [ValW-1:0] piv_sel;
  logic                   rp_go;
  logic signed [BW-1:0]   rp_src;
  logic [PIW-1:0]         bidx;
  assign piv_sel = piv_q[idx_q[PIW-1:0]];
  assign bidx    = dir_hi_q ? (idx_q[PIW-1:0] + PIW'(1)) : idx_q[PIW-1:0];
  assign rp_src  = bnd_q[bidx];
  always_comb begin
    if (dir_hi_q) begin
      rp_go = (idx_q < IW'(NUM_PIVOTS - 1)) && (cur_v_q > piv_sel);
    end else begin
      rp_go = !idx_q[IW-1] && (cur_v_q <= piv_sel);
    end
  end

  // Memory control per state.
  always_comb begin
    m_we    = 1'b0;
    m_re    = 1'b0;
    m_waddr = '0;
    m_raddr = '0;
    m_wdata = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && el_ok && (action_i == ACT_LOAD_EL)) begin
          m_we    = 1'b1;
          m_waddr = AW'(address_i);
          m_wdata = '{value: data_value_i, origin: address_i};
        end
        if (in_acc && el_ok && (action_i == ACT_READ_EL)) begin
          m_re    = 1'b1;
          m_raddr = AW'(address_i);
        end
      end
      S_L_CHK: begin
        m_re    = (lh <= rh);
        m_raddr = slot(lh);
      end
      S_R_CHK: begin
        m_re    = (lh <= rh);
        m_raddr = slot(rh);
      end
      S_R_EV: begin
        m_re    = 1'b1;
        m_raddr = slot(lh);
      end
      S_RP_STEP: begin
        if (rp_go) begin
          m_re    = 1'b1;
          m_raddr = slot(rp_src);
        end else if (ret_q == RET_SWL) begin
          m_we    = 1'b1;
          m_waddr = slot(hole_hi_q);
          m_wdata = '{value: rv_q, origin: ro_q};
        end else if (ret_q != RET_SWH) begin
          m_we    = 1'b1;
          m_waddr = slot(hole_q);
          m_wdata = '{value: cur_v_q, origin: cur_o_q};
        end
      end
      S_RP_MOVE: begin
        m_we    = 1'b1;
        m_waddr = slot(hole_q);
        m_wdata = m_rdata;
      end
      S_PUT_LO: begin
        m_we    = 1'b1;
        m_waddr = slot(hole_q);
        m_wdata = '{value: cur_v_q, origin: cur_o_q};
      end
      default: ;
    endcase
  end

  // Sequencer, tables and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= RET_L;
      dir_hi_q <= 1'b0;
      len_q    <= LenW'(4096);
      ov_q     <= 1'b0;
      for (int k = 0; k < NUM_PIVOTS; k++) begin
        bnd_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (out_acc) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            rval_q <= '0;
            rorg_q <= '0;
            rbnd_q <= '0;
            done_q <= 1'b0;
            ov_q   <= 1'b1;
            case (action_i)
              ACT_LOAD_PIV: begin
                if (piv_ok) begin
                  piv_q[PIW'(address_i)] <= data_value_i;
                end
              end
              ACT_START: begin
                ov_q    <= 1'b0;
                mp_q    <= piv_q[MID-1];
                state_q <= S_L_CHK;
                for (int k = 0; k < NUM_PIVOTS; k++) begin
                  bnd_q[k] <= (k < MID) ? '0 : len_m1;
                end
              end
              ACT_READ_EL: begin
                if (el_ok) begin
                  ov_q    <= 1'b0;
                  state_q <= S_RDEL;
                end
              end
              ACT_READ_BND: begin
                if (piv_ok) begin
                  rbnd_q <= BndOW'(bnd_q[PIW'(address_i)]);
                end
              end
              default: ;
            endcase
          end
        end
        S_RDEL: begin
          rval_q  <= m_rdata.value;
          rorg_q  <= m_rdata.origin;
          ov_q    <= 1'b1;
          state_q <= S_IDLE;
        end
        S_L_CHK: begin
          if (lh <= rh) begin
            state_q <= S_L_EV;
          end else begin
            done_q  <= 1'b1;
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_L_EV: begin
          if (m_rdata.value <= mp_q) begin
            cur_v_q  <= m_rdata.value;
            cur_o_q  <= m_rdata.origin;
            hole_q   <= lh;
            idx_q    <= IW'(MID) - IW'(2);
            dir_hi_q <= 1'b0;
            ret_q    <= RET_L;
            state_q  <= S_RP_STEP;
          end else begin
            state_q <= S_R_CHK;
          end
        end
        S_R_CHK: begin
          if (lh <= rh) begin
            state_q <= S_R_EV;
          end else begin
            done_q  <= 1'b1;
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_R_EV: begin
          if (m_rdata.value > mp_q) begin
            cur_v_q  <= m_rdata.value;
            cur_o_q  <= m_rdata.origin;
            hole_q   <= rh;
            idx_q    <= IW'(MID);
            dir_hi_q <= 1'b1;
            ret_q    <= RET_R;
            state_q  <= S_RP_STEP;
          end else begin
            // Misplaced pair: keep the right element, the left one is read now.
            rv_q    <= m_rdata.value;
            ro_q    <= m_rdata.origin;
            state_q <= S_SW_EV;
          end
        end
        S_SW_EV: begin
          cur_v_q  <= m_rdata.value;
          cur_o_q  <= m_rdata.origin;
          hole_q   <= rh;
          idx_q    <= IW'(MID);
          dir_hi_q <= 1'b1;
          ret_q    <= RET_SWH;
          state_q  <= S_RP_STEP;
        end
        S_RP_STEP: begin
          if (rp_go) begin
            src_q   <= rp_src;
            state_q <= S_RP_MOVE;
          end else begin
            case (ret_q)
              RET_L: begin
                bnd_q[MID-1] <= lh + BW'(1);
                state_q      <= S_L_CHK;
              end
              RET_R: begin
                bnd_q[MID] <= rh - BW'(1);
                state_q    <= S_R_CHK;
              end
              RET_SWH: begin
                // Left value waits for its hole; ripple the right value down.
                hole_hi_q <= hole_q;
                cur_v_q   <= rv_q;
                cur_o_q   <= ro_q;
                rv_q      <= cur_v_q;
                ro_q      <= cur_o_q;
                hole_q    <= lh;
                idx_q     <= IW'(MID) - IW'(2);
                dir_hi_q  <= 1'b0;
                ret_q     <= RET_SWL;
              end
              default: begin
                state_q <= S_PUT_LO;
              end
            endcase
          end
        end
        S_RP_MOVE: begin
          hole_q <= src_q;
          if (dir_hi_q) begin
            bnd_q[bidx] <= bnd_q[bidx] - BW'(1);
            idx_q       <= idx_q + IW'(1);
          end else begin
            bnd_q[bidx] <= bnd_q[bidx] + BW'(1);
            idx_q       <= idx_q - IW'(1);
          end
          state_q <= S_RP_STEP;
        end
        S_PUT_LO: begin
          bnd_q[MID-1] <= lh + BW'(1);
          bnd_q[MID]   <= rh - BW'(1);
          state_q      <= S_L_CHK;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = ov_q;
  assign read_value_o     = rval_q;
  assign origin_index_o   = rorg_q;
  assign boundary_value_o = rbnd_q;
  assign run_done_o       = done_q;

endmodule

// ===== rtl/mip_store.sv =====
// ----------------------------------------------------------------------------
// mip_store
// Element and origin memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module mip_store
  import mip_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  elem_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output elem_t         rdata_o
);

  elem_t mem [DEPTH];
  elem_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
